// ----- rtl/apm_pkg.sv -----
`default_nettype none
package apm_pkg;

    // Sample width; the peak-to-peak, payload and config data widths follow from it.
    localparam int SAMPLE_BITS = 10;
    localparam int RANGE_BITS  = 3;
    localparam int PP_BITS     = SAMPLE_BITS + 1;

    // Stream widths; the tdata payloads are padded to whole bytes.
    localparam int IN_DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int IN_USER_W   = 2;
    localparam int REPORT_W    = PP_BITS + RANGE_BITS + 1;
    localparam int OUT_DATA_W  = ((2 * REPORT_W + 7) / 8) * 8;

    // Config port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = (SAMPLE_BITS > RANGE_BITS) ? SAMPLE_BITS : RANGE_BITS;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [RANGE_BITS-1:0]  HV_TOP_RESET = RANGE_BITS'(2);
    localparam logic [RANGE_BITS-1:0]  FB_TOP_RESET = RANGE_BITS'(4);
    localparam logic [SAMPLE_BITS-1:0] SAT_RESET    = SAMPLE_BITS'(820);

    // Item kinds (tuser).
    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_WEND   = 2'd2;
    localparam logic [1:0] MODE_END    = 2'd3;

    // Config register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HV_TOP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FB_TOP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAT    = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [RANGE_BITS-1:0] range;
        logic signed [PP_BITS-1:0] pp;
    } t_report;

endpackage
`default_nettype wire

// ----- rtl/autorange_peak_to_peak_meter.sv -----
`default_nettype none
// Two-channel autoranging peak-to-peak meter.
//
// Input stream (s_axis): tuser carries the item kind (begin, sample pair,
// window end, end); tdata carries the hv and fb ADC readings. Each channel
// is a lane of its own; the hv lane's saturation flag gates the fb lane in
// the same cycle, and a merge stage packs both reports into one result.
// Output stream (m_axis): one result per window-end item, peak-to-peak,
// range index and valid flag for each channel.
// Config port: index 0 hv top range, 1 fb top range, 2 saturation level;
// always ready, writes to index 3 are dropped.
// Throughput: one item per cycle while s_axis_tready is high. Each window-end
// result is registered in the output register, or in the skid stage if that is full.
// A stalled receiver fills the output register and then a one-entry skid
// stage; s_axis_tready drops only when both hold a result.
// Reset (synchronous, active low) clears indices, peaks, stuck flags and
// both output stages, and loads the config registers with 2, 4 and 820.
module autorange_peak_to_peak_meter (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // tdata: hv_sample, fb_sample, zero pad
    input  wire  [apm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // tuser: mode
    input  wire  [apm_pkg::IN_USER_W-1:0]        s_axis_tuser,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: hv_peak_to_peak, hv_range, hv_valid,
    //        fb_peak_to_peak, fb_range, fb_valid, zero pad
    output logic [apm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [apm_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire  [apm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int SB = apm_pkg::SAMPLE_BITS;

    logic [apm_pkg::RANGE_BITS-1:0] r_hv_top;
    logic [apm_pkg::RANGE_BITS-1:0] r_fb_top;
    logic [SB-1:0]                  r_sat;

    logic                 w_accept;
    logic [1:0]           w_mode;
    logic [SB-1:0]        w_hv_sample;
    logic [SB-1:0]        w_fb_sample;
    logic                 w_hv_skip;
    logic                 w_fb_skip;
    apm_pkg::t_report     w_hv_report;
    apm_pkg::t_report     w_fb_report;
    logic                 w_push;

    assign w_mode      = s_axis_tuser[1:0];
    assign w_hv_sample = s_axis_tdata[SB-1:0];
    assign w_fb_sample = s_axis_tdata[2*SB-1:SB];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_push      = w_accept && (w_mode == apm_pkg::MODE_WEND);

    // Config registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv_top <= apm_pkg::HV_TOP_RESET;
            r_fb_top <= apm_pkg::FB_TOP_RESET;
            r_sat    <= apm_pkg::SAT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                apm_pkg::CFG_HV_TOP: r_hv_top <= i_cfg_data[apm_pkg::RANGE_BITS-1:0];
                apm_pkg::CFG_FB_TOP: r_fb_top <= i_cfg_data[apm_pkg::RANGE_BITS-1:0];
                apm_pkg::CFG_SAT:    r_sat    <= i_cfg_data[SB-1:0];
                default: begin
                    r_sat <= r_sat;
                end
            endcase
        end
    end

    // hv lane goes first; its saturation skips the fb reading.
    apm_lane u_hv_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_mode      (w_mode),
        .i_sample    (w_hv_sample),
        .i_enable    (1'b1),
        .i_top_range (r_hv_top),
        .i_sat_level (r_sat),
        .o_skip      (w_hv_skip),
        .o_report    (w_hv_report)
    );

    apm_lane u_fb_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_mode      (w_mode),
        .i_sample    (w_fb_sample),
        .i_enable    (!w_hv_skip),
        .i_top_range (r_fb_top),
        .i_sat_level (r_sat),
        .o_skip      (w_fb_skip),
        .o_report    (w_fb_report)
    );

    apm_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_hv    (w_hv_report),
        .i_fb    (w_fb_report),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_taken (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_one_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_hv_skip && w_fb_skip))
        else $error("both lanes saturated on one sample");
`endif

endmodule
`default_nettype wire

// ----- rtl/apm_lane.sv -----
`default_nettype none
// One measurement channel: range index, window peaks, stuck flag.
module apm_lane (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_accept,
    input  wire  [1:0]                          i_mode,
    input  wire  [apm_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  wire                                 i_enable,   // low: reading skipped
    input  wire  [apm_pkg::RANGE_BITS-1:0]      i_top_range,
    input  wire  [apm_pkg::SAMPLE_BITS-1:0]     i_sat_level,
    output logic                                o_skip,     // saturated this item
    output apm_pkg::t_report                    o_report
);

    logic [apm_pkg::RANGE_BITS-1:0]  r_index, n_index;
    logic [apm_pkg::RANGE_BITS-1:0]  r_saved, n_saved;
    logic [apm_pkg::SAMPLE_BITS-1:0] r_high, n_high;
    logic [apm_pkg::SAMPLE_BITS-1:0] r_low, n_low;
    logic                            r_stuck, n_stuck;
    logic                            w_live;
    logic                            w_sat;

    assign w_live = (i_mode == apm_pkg::MODE_SAMPLE) && i_enable && !r_stuck;
    assign w_sat  = i_sample > i_sat_level;
    assign o_skip = w_live && w_sat;

    always_comb begin
        n_index = r_index;
        n_saved = r_saved;
        n_high  = r_high;
        n_low   = r_low;
        n_stuck = r_stuck;
        if (i_accept) begin
            unique case (i_mode)
                apm_pkg::MODE_BEGIN: begin
                    n_saved = r_index;
                    n_index = i_top_range;
                    n_high  = '0;
                    n_low   = apm_pkg::FULL_SCALE;
                    n_stuck = 1'b0;
                end
                apm_pkg::MODE_SAMPLE: begin
                    if (w_live) begin
                        if (w_sat) begin
                            if (r_index != '0) begin
                                n_index = r_index - apm_pkg::RANGE_BITS'(1);
                                n_high  = '0;
                                n_low   = apm_pkg::FULL_SCALE;
                            end else begin
                                n_stuck = 1'b1;
                            end
                        end else begin
                            if (i_sample > r_high) n_high = i_sample;
                            if (i_sample < r_low)  n_low  = i_sample;
                        end
                    end
                end
                apm_pkg::MODE_WEND: begin
                    n_high  = '0;
                    n_low   = apm_pkg::FULL_SCALE;
                    n_stuck = 1'b0;
                end
                apm_pkg::MODE_END: begin
                    n_index = r_saved;
                end
                default: begin
                    n_index = r_index;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_saved <= '0;
            r_high  <= '0;
            r_low   <= apm_pkg::FULL_SCALE;
            r_stuck <= 1'b0;
        end else begin
            r_index <= n_index;
            r_saved <= n_saved;
            r_high  <= n_high;
            r_low   <= n_low;
            r_stuck <= n_stuck;
        end
    end

    // Report of the current window.
    always_comb begin
        o_report.pp    = $signed({1'b0, r_high}) - $signed({1'b0, r_low});
        o_report.range = r_index;
        o_report.valid = !((r_high == '0) || ((r_low == apm_pkg::FULL_SCALE) && !r_stuck));
    end

`ifndef SYNTHESIS
    a_index_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_index) && $stable(r_saved))
        else $error("range index moved without an item");

    a_peaks_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high != '0) |-> (r_low <= r_high))
        else $error("window minimum above maximum");

    a_wend_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_mode == apm_pkg::MODE_WEND)) |=>
            (r_high == '0) && (r_low == apm_pkg::FULL_SCALE) && !r_stuck)
        else $error("window end did not clear the window");
`endif

endmodule
`default_nettype wire

// ----- rtl/apm_merge.sv -----
`default_nettype none
// Joins the two lane reports into one result and holds it in an
// output register backed by a skid stage.
module apm_merge (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_push,
    input  apm_pkg::t_report                    i_hv,
    input  apm_pkg::t_report                    i_fb,
    output logic                                o_ready,
    output logic                                o_valid,
    input  wire                                 i_taken,
    output logic [apm_pkg::OUT_DATA_W-1:0]      o_data
);

    localparam int PAD_W = apm_pkg::OUT_DATA_W - 2 * apm_pkg::REPORT_W;

    logic [apm_pkg::OUT_DATA_W-1:0] w_word;
    logic [apm_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [apm_pkg::OUT_DATA_W-1:0] r_skid_data;
    logic                           r_out_valid;
    logic                           r_skid_valid;
    logic                           w_pop;

    generate
        if (PAD_W > 0) begin : g_pad
            assign w_word = {{PAD_W{1'b0}}, i_fb, i_hv};
        end else begin : g_nopad
            assign w_word = {i_fb, i_hv};
        end
    endgenerate

    assign w_pop   = r_out_valid && i_taken;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !w_pop) begin
            if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !w_pop) begin
            if (i_push) r_skid_data <= w_word;
        end else if (r_skid_valid) begin
            r_out_data <= r_skid_data;
        end else if (i_push) begin
            r_out_data <= w_word;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full with output register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_pop) |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid stage overwritten");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_pop) |=> r_out_valid && (r_out_data == $past(r_skid_data)))
        else $error("skid item lost");
`endif

endmodule
`default_nettype wire

// ----- tb/autorange_peak_to_peak_meter_tb.sv -----
`timescale 1ns / 1ps

module autorange_peak_to_peak_meter_tb;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 8;       // output register plus skid stage, with margin
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SEGMENTS      = 6;
    localparam int SEG_ITEMS     = 65;
    localparam int SB            = apm_pkg::SAMPLE_BITS;
    localparam int RB            = apm_pkg::RANGE_BITS;

    // One expected window-end report: lane 0 is hv, lane 1 is fb.
    typedef struct {
        apm_pkg::t_report lane[2];
    } t_window_result;

    // Tracks both channels' ranges, peaks and stuck flags from the accepted
    // items and checks each report the meter sends out.
    class window_report_checker;
        bit [RB-1:0]          top_range[2];
        bit [SB-1:0]          sat_level;
        bit [RB-1:0]          range_idx[2];
        bit [RB-1:0]          saved_idx[2];
        bit [SB-1:0]          peak_hi[2];
        bit [SB-1:0]          peak_lo[2];
        bit                   stuck[2];
        t_window_result       pending_reports[$];
        int                   mismatches;

        function new();
            top_range[0] = apm_pkg::HV_TOP_RESET;
            top_range[1] = apm_pkg::FB_TOP_RESET;
            sat_level    = apm_pkg::SAT_RESET;
            mismatches   = 0;
            for (int c = 0; c < 2; c++) begin
                range_idx[c] = '0;
                saved_idx[c] = '0;
                clear_window(c);
            end
        endfunction

        function void clear_window(int c);
            peak_hi[c] = '0;
            peak_lo[c] = apm_pkg::FULL_SCALE;
            stuck[c]   = 1'b0;
        endfunction

        function void set_reg(logic [apm_pkg::CFG_INDEX_W-1:0] idx,
                              logic [apm_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                apm_pkg::CFG_HV_TOP: top_range[0] = val[RB-1:0];
                apm_pkg::CFG_FB_TOP: top_range[1] = val[RB-1:0];
                apm_pkg::CFG_SAT:    sat_level    = val[SB-1:0];
                default:    ;
            endcase
        endfunction

        // Returns 1 when a live reading saturated; for hv that skips the fb lane.
        function bit take_reading(int c, bit [SB-1:0] v);
            if (stuck[c])
                return 1'b0;
            if (v > sat_level) begin
                if (range_idx[c] != 0) begin
                    range_idx[c] = range_idx[c] - 1'b1;
                    peak_hi[c]   = '0;
                    peak_lo[c]   = apm_pkg::FULL_SCALE;
                end else begin
                    stuck[c] = 1'b1;
                end
                return 1'b1;
            end
            if (v > peak_hi[c])
                peak_hi[c] = v;
            if (v < peak_lo[c])
                peak_lo[c] = v;
            return 1'b0;
        endfunction

        function void note_item(logic [1:0] mode, logic [SB-1:0] hs, logic [SB-1:0] fs);
            t_window_result r;
            case (mode)
                apm_pkg::MODE_BEGIN: begin
                    for (int c = 0; c < 2; c++) begin
                        saved_idx[c] = range_idx[c];
                        range_idx[c] = top_range[c];
                        clear_window(c);
                    end
                end
                apm_pkg::MODE_SAMPLE: begin
                    if (!take_reading(0, hs))
                        void'(take_reading(1, fs));
                end
                apm_pkg::MODE_WEND: begin
                    for (int c = 0; c < 2; c++) begin
                        r.lane[c].pp    = {1'b0, peak_hi[c]} - {1'b0, peak_lo[c]};
                        r.lane[c].range = range_idx[c];
                        r.lane[c].valid = !((peak_hi[c] == 0) ||
                                            (peak_lo[c] == apm_pkg::FULL_SCALE &&
                                             !stuck[c]));
                        clear_window(c);
                    end
                    pending_reports.push_back(r);
                end
                apm_pkg::MODE_END: begin
                    for (int c = 0; c < 2; c++)
                        range_idx[c] = saved_idx[c];
                end
                default: ;
            endcase
        endfunction

        function void check_report(logic [apm_pkg::OUT_DATA_W-1:0] data);
            t_window_result   e;
            apm_pkg::t_report got;
            string            nm;
            if (pending_reports.size() == 0) begin
                $error("report with no window end pending: %h", data);
                mismatches++;
                return;
            end
            e = pending_reports.pop_front();
            for (int c = 0; c < 2; c++) begin
                got = data[c*apm_pkg::REPORT_W +: apm_pkg::REPORT_W];
                nm  = (c == 0) ? "hv" : "fb";
                if (got.pp !== e.lane[c].pp) begin
                    $error("%s_peak_to_peak: expected %0d, got %0d", nm, e.lane[c].pp, got.pp);
                    mismatches++;
                end
                if (got.range !== e.lane[c].range) begin
                    $error("%s_range: expected %0d, got %0d", nm, e.lane[c].range, got.range);
                    mismatches++;
                end
                if (got.valid !== e.lane[c].valid) begin
                    $error("%s_valid: expected %0d, got %0d", nm, e.lane[c].valid, got.valid);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic [apm_pkg::IN_DATA_W-1:0]     s_axis_tdata;    // hv_sample, fb_sample, zero pad
    logic [apm_pkg::IN_USER_W-1:0]     s_axis_tuser;    // mode
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [apm_pkg::OUT_DATA_W-1:0]    m_axis_tdata;    // hv pp, hv range, hv valid,
                                                        // fb pp, fb range, fb valid, zero pad
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [apm_pkg::CFG_INDEX_W-1:0]   i_cfg_index;
    logic [apm_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    window_report_checker meter_model;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   cycles;

    autorange_peak_to_peak_meter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: stops a hung run with an error.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $error("timeout, %0d reports still pending", meter_model.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver backpressure: a fresh coin per cycle, so stalls land on every
    // phase of the output register / skid stage.
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Every accepted report is checked against the oldest pending window.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            meter_model.check_report(m_axis_tdata);
    end

    // Present one item and hold it until taken. tvalid stays high between
    // back-to-back items unless the sender decides to idle.
    task automatic push_item(input logic [1:0] mode, input logic [SB-1:0] hs,
                             input logic [SB-1:0] fs);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = '0;
        s_axis_tdata[SB-1:0]    = hs;
        s_axis_tdata[2*SB-1:SB] = fs;
        do @(posedge i_clk); while (!s_axis_tready);
        meter_model.note_item(mode, hs, fs);
    endtask

    // Stop sending and let every pending report come out; window-end is the
    // only item with a result, but let the pipe settle afterwards anyway.
    task automatic drain_meter();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (meter_model.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [apm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [apm_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        meter_model.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_ranges(input int hv_top, input int fb_top, input int sat);
        write_reg(apm_pkg::CFG_HV_TOP, apm_pkg::CFG_DATA_W'(hv_top));
        write_reg(apm_pkg::CFG_FB_TOP, apm_pkg::CFG_DATA_W'(fb_top));
        write_reg(apm_pkg::CFG_SAT, apm_pkg::CFG_DATA_W'(sat));
    endtask

    // Random reading of full ADC width.
    function automatic logic [SB-1:0] any_reading();
        return SB'($urandom);
    endfunction

    // Mostly in-range readings, some saturating, a few anywhere.
    function automatic logic [SB-1:0] pick_reading();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return SB'($urandom_range(meter_model.sat_level));
        if (r < 90 && meter_model.sat_level < apm_pkg::FULL_SCALE)
            return SB'($urandom_range(apm_pkg::FULL_SCALE, meter_model.sat_level + 1));
        return SB'($urandom_range(apm_pkg::FULL_SCALE));
    endfunction

    // Mostly whole measurements: begin, a few windows of readings each closed
    // by window end, then end. The rest is loose items of any kind.
    task automatic run_measurements(input int n_items);
        int sent;
        int n_win;
        int n_samp;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 8) begin
                push_item(apm_pkg::MODE_BEGIN, any_reading(), any_reading());
                sent++;
                n_win = $urandom_range(3, 1);
                repeat (n_win) begin
                    n_samp = $urandom_range(8);
                    repeat (n_samp) begin
                        push_item(apm_pkg::MODE_SAMPLE, pick_reading(), pick_reading());
                        sent++;
                    end
                    push_item(apm_pkg::MODE_WEND, any_reading(), any_reading());
                    sent++;
                end
                push_item(apm_pkg::MODE_END, any_reading(), any_reading());
                sent++;
            end else begin
                push_item(2'($urandom_range(3)), pick_reading(), pick_reading());
                sent++;
            end
        end
    endtask

    initial begin
        meter_model   = new();
        send_idle_pct = 22;
        recv_idle_pct = 73;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset config (hv top 2, fb top 4, saturation 820).
        // Before any begin: empty window, then hv saturates at range 0.
        push_item(apm_pkg::MODE_WEND, 10'h3FF, 10'h3FF);
        push_item(apm_pkg::MODE_SAMPLE, 10'd1023, 10'd0);    // hv stuck, fb skipped
        push_item(apm_pkg::MODE_SAMPLE, 10'd5, 10'd0);       // hv ignores, fb takes zero
        push_item(apm_pkg::MODE_WEND, 10'd0, 10'd0);         // fb high is 0: not valid
        push_item(apm_pkg::MODE_END, 10'd0, 10'd0);          // restore before any begin
        push_item(apm_pkg::MODE_BEGIN, 10'h2AA, 10'h155);
        push_item(apm_pkg::MODE_SAMPLE, 10'd0, 10'd1023);    // fb steps down
        push_item(apm_pkg::MODE_SAMPLE, 10'd820, 10'd820);   // right at the level: kept
        push_item(apm_pkg::MODE_SAMPLE, 10'd821, 10'd1);     // hv steps down, fb skipped
        push_item(apm_pkg::MODE_SAMPLE, 10'd1023, 10'd1023); // hv to range 0
        push_item(apm_pkg::MODE_SAMPLE, 10'd300, 10'd400);
        push_item(apm_pkg::MODE_SAMPLE, 10'd1023, 10'd10);   // hv stuck with readings: valid
        push_item(apm_pkg::MODE_SAMPLE, 10'd500, 10'd1023);  // fb steps down again
        push_item(apm_pkg::MODE_WEND, 10'd0, 10'd0);
        push_item(apm_pkg::MODE_SAMPLE, 10'd700, 10'd300);
        push_item(apm_pkg::MODE_SAMPLE, 10'd1, 10'd819);
        push_item(apm_pkg::MODE_WEND, 10'd0, 10'd0);
        push_item(apm_pkg::MODE_BEGIN, 10'd0, 10'd0);        // repeated begin overwrites saved
        push_item(apm_pkg::MODE_SAMPLE, 10'd1022, 10'd1022);
        push_item(apm_pkg::MODE_END, 10'h3FF, 10'h3FF);
        push_item(apm_pkg::MODE_WEND, 10'd0, 10'd0);         // end keeps the peaks
        push_item(apm_pkg::MODE_SAMPLE, 10'd512, 10'd256);
        push_item(apm_pkg::MODE_WEND, 10'd0, 10'd0);

        // Random part: two segments per idle pattern, each under its own config.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_meter();
            case (seg / 2)
                0: begin send_idle_pct = 22; recv_idle_pct = 73; end
                1: begin send_idle_pct = 73; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0: set_ranges(7, 0, 1023);  // nothing saturates
                1: set_ranges(0, 7, 0);     // any nonzero reading saturates
                2: set_ranges(7, 7, $urandom_range(1023, 700));
                default: set_ranges($urandom_range(7), $urandom_range(7),
                                    $urandom_range(1023, 400));
            endcase
            run_measurements(SEG_ITEMS);
        end
        drain_meter();

        if (meter_model.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
